// ===== rtl/gcpd_pkg.sv =====
// Shared types, codes and opcode tables of the GPU command packet decoder.
package gcpd_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_PACKET_WORDS_DEF = 16;
  localparam int FRAME_WIDTH_DEF      = 1024;
  localparam int FRAME_HEIGHT_DEF     = 512;

  // Depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] KIND_BUFFERED = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_PIXEL    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Command classes.
  localparam logic [3:0] CLS_NOP     = 4'd0;
  localparam logic [3:0] CLS_CACHE   = 4'd1;
  localparam logic [3:0] CLS_FILL    = 4'd2;
  localparam logic [3:0] CLS_POLYGON = 4'd3;
  localparam logic [3:0] CLS_LINE    = 4'd4;
  localparam logic [3:0] CLS_RECT    = 4'd5;
  localparam logic [3:0] CLS_COPY    = 4'd6;
  localparam logic [3:0] CLS_LOAD    = 4'd7;
  localparam logic [3:0] CLS_STORE   = 4'd8;
  localparam logic [3:0] CLS_ATTR    = 4'd9;
  localparam logic [3:0] CLS_UNKNOWN = 4'd15;

  // Opcodes with a meaning of their own.
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_CACHE     = 8'h01;
  localparam logic [7:0] OP_FILL      = 8'h02;
  localparam logic [7:0] OP_ATTR_LO   = 8'hE1;
  localparam logic [7:0] OP_ATTR_HI   = 8'hE6;

  // Attribute register selects, taken from the low opcode bits.
  localparam logic [2:0] ATTR_MODE   = 3'd1;
  localparam logic [2:0] ATTR_WINDOW = 3'd2;
  localparam logic [2:0] ATTR_TL     = 3'd3;
  localparam logic [2:0] ATTR_BR     = 3'd4;
  localparam logic [2:0] ATTR_OFFSET = 3'd5;
  localparam logic [2:0] ATTR_MASK   = 3'd6;

  // One queued unit of work: a packet result or one pixel word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  cls;
    logic        two;
    logic [9:0]  x0;
    logic [8:0]  y0;
    logic [15:0] v0;
    logic [9:0]  x1;
    logic [8:0]  y1;
    logic [15:0] v1;
    logic        attr_we;
    logic [2:0]  attr_sel;
    logic [21:0] attr_val;
  } gcpd_entry_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  command_class;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [15:0] pixel_value;
    logic        last_in_run;
    logic [13:0] draw_mode;
    logic [19:0] texture_window;
    logic [19:0] area_top_left;
    logic [19:0] area_bottom_right;
    logic [21:0] drawing_offset;
    logic [1:0]  mask_setting;
  } gcpd_result_t;

  // Fixed word count of a packet, taken from its opcode.
  function automatic logic [4:0] words_for(input logic [7:0] op);
    logic [4:0] v;
    logic [4:0] n;
    begin
      v = op[3] ? 5'd4 : 5'd3;
      n = 5'd1;
      if (op == OP_FILL) begin
        n = 5'd3;
      end else if (op < 8'h20) begin
        n = 5'd1;
      end else if (op < 8'h40) begin
        n = 5'd1 + (op[2] ? 5'(v << 1) : v) + (op[4] ? v - 5'd1 : 5'd0);
      end else if (op < 8'h48) begin
        n = 5'd3;
      end else if (op < 8'h50) begin
        n = 5'd16;
      end else if (op < 8'h58) begin
        n = 5'd4;
      end else if (op < 8'h60) begin
        n = 5'd16;
      end else if (op < 8'h80) begin
        n = 5'd2 + ((op[4:3] == 2'b00) ? 5'd1 : 5'd0) + (op[2] ? 5'd1 : 5'd0);
      end else if (op < 8'hA0) begin
        n = 5'd4;
      end else if (op < 8'hE0) begin
        n = 5'd3;
      end
      return n;
    end
  endfunction

  // Command class of an opcode, CLS_UNKNOWN where it has none.
  function automatic logic [3:0] class_of(input logic [7:0] op);
    logic [3:0] c;
    begin
      c = CLS_UNKNOWN;
      if (op == OP_NOP) begin
        c = CLS_NOP;
      end else if (op == OP_CACHE) begin
        c = CLS_CACHE;
      end else if (op == OP_FILL) begin
        c = CLS_FILL;
      end else if (op < 8'h20) begin
        c = CLS_UNKNOWN;
      end else if (op < 8'h40) begin
        c = CLS_POLYGON;
      end else if (op < 8'h60) begin
        c = CLS_LINE;
      end else if (op < 8'h80) begin
        c = CLS_RECT;
      end else if (op < 8'hA0) begin
        c = CLS_COPY;
      end else if (op < 8'hC0) begin
        c = CLS_LOAD;
      end else if (op < 8'hE0) begin
        c = CLS_STORE;
      end else if (op >= OP_ATTR_LO && op <= OP_ATTR_HI) begin
        c = CLS_ATTR;
      end
      return c;
    end
  endfunction

endpackage

// ===== rtl/gcpd_intf.sv =====
// Handshake interfaces of the command word and result channels.
interface gcpd_cmd_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

interface gcpd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  command_class;
  logic [9:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [15:0] pixel_value;
  logic        last_in_run;
  logic [13:0] draw_mode;
  logic [19:0] texture_window;
  logic [19:0] area_top_left;
  logic [19:0] area_bottom_right;
  logic [21:0] drawing_offset;
  logic [1:0]  mask_setting;

  modport source (
    output valid, output result_kind, output command_class, output pixel_x,
    output pixel_y, output pixel_value, output last_in_run, output draw_mode,
    output texture_window, output area_top_left, output area_bottom_right,
    output drawing_offset, output mask_setting, input ready
  );
  modport sink (
    input valid, input result_kind, input command_class, input pixel_x,
    input pixel_y, input pixel_value, input last_in_run, input draw_mode,
    input texture_window, input area_top_left, input area_bottom_right,
    input drawing_offset, input mask_setting, output ready
  );
endinterface

// ===== rtl/gcpd_front.sv =====
// Front end: gathers packets, classifies commands and tracks the pixel transfer.
module gcpd_front import gcpd_pkg::*; #(
  parameter int MAX_PACKET_WORDS = MAX_PACKET_WORDS_DEF,
  parameter int FRAME_WIDTH      = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT     = FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] in_data,
  output logic        in_ready,
  input  logic        q_full,
  output logic        push,
  output gcpd_entry_t push_entry
);

  localparam int CW      = $clog2(MAX_PACKET_WORDS + 1);
  localparam int XW      = $clog2(FRAME_WIDTH);
  localparam int YW      = $clog2(FRAME_HEIGHT);
  localparam int RECIP_X = (1 << 24) / FRAME_WIDTH;
  localparam int RECIP_Y = (1 << 24) / FRAME_HEIGHT;

  // Packet state.
  logic [CW-1:0] count, count_next;
  logic [7:0]    op_byte;
  logic [21:0]   op_low;
  logic [15:0]   w1_x, w1_y;
  logic [15:0]   q_x, q_y;

  // Transfer state.
  logic          active, active_next;
  logic [15:0]   t_width, t_width_next;
  logic [15:0]   t_height, t_height_next;
  logic [15:0]   col, col_next;
  logic [15:0]   row, row_next;
  logic [XW-1:0] base_x, base_x_next, cur_x, cur_x_next;
  logic [YW-1:0] base_y, base_y_next, cur_y, cur_y_next;

  function automatic logic [XW-1:0] step_x(input logic [XW-1:0] v);
    return (v == XW'(FRAME_WIDTH - 1)) ? '0 : v + XW'(1);
  endfunction

  function automatic logic [YW-1:0] step_y(input logic [YW-1:0] v);
    return (v == YW'(FRAME_HEIGHT - 1)) ? '0 : v + YW'(1);
  endfunction

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Opcode and word count of the packet being gathered.
  logic [7:0]  op;
  logic [21:0] attr_val;
  logic [4:0]  need_raw;
  logic [5:0]  need, count_inc;
  logic [3:0]  cls;

  assign op        = (count == '0) ? in_data[31:24] : op_byte;
  assign attr_val  = (count == '0) ? in_data[21:0] : op_low;
  assign need_raw  = words_for(op);
  assign need      = (6'(need_raw) > 6'(MAX_PACKET_WORDS)) ? 6'(MAX_PACKET_WORDS)
                                                           : 6'(need_raw);
  assign count_inc = 6'(count) + 6'd1;
  assign cls       = class_of(op);

  // Start coordinate reduced modulo the frame size: the quotient estimate is
  // registered when the coordinate word arrives and corrected at packet end.
  logic [40:0] prod_x, prod_y;
  logic [27:0] qw_x, qw_y, rx, ry;
  logic [XW-1:0] start_x_mod;
  logic [YW-1:0] start_y_mod;

  assign prod_x = 41'(in_data[15:0]) * 41'(RECIP_X);
  assign prod_y = 41'(in_data[31:16]) * 41'(RECIP_Y);
  assign qw_x   = 28'(q_x) * 28'(FRAME_WIDTH);
  assign qw_y   = 28'(q_y) * 28'(FRAME_HEIGHT);
  assign rx     = 28'(w1_x) - qw_x;
  assign ry     = 28'(w1_y) - qw_y;
  assign start_x_mod = (rx >= 28'(FRAME_WIDTH)) ? XW'(rx - 28'(FRAME_WIDTH)) : XW'(rx);
  assign start_y_mod = (ry >= 28'(FRAME_HEIGHT)) ? YW'(ry - 28'(FRAME_HEIGHT)) : YW'(ry);

  // Two halfword steps of the transfer walk, chained.
  logic [16:0]   c1, r1, c2, r2;
  logic          wrap0, end0, wrap1, end1;
  logic [15:0]   col_a, row_a;
  logic [XW-1:0] x_a;
  logic [YW-1:0] y_a;

  assign c1    = {1'b0, col} + 17'd1;
  assign r1    = {1'b0, row} + 17'd1;
  assign wrap0 = c1 >= {1'b0, t_width};
  assign end0  = wrap0 && (r1 >= {1'b0, t_height});
  assign col_a = wrap0 ? 16'd0 : c1[15:0];
  assign row_a = wrap0 ? r1[15:0] : row;
  assign x_a   = wrap0 ? base_x : step_x(cur_x);
  assign y_a   = wrap0 ? step_y(cur_y) : cur_y;

  assign c2    = {1'b0, col_a} + 17'd1;
  assign r2    = {1'b0, row_a} + 17'd1;
  assign wrap1 = c2 >= {1'b0, t_width};
  assign end1  = wrap1 && (r2 >= {1'b0, t_height});

  // Next state and queue entry for the beat on the input.
  always_comb begin
    count_next    = count;
    active_next   = active;
    t_width_next  = t_width;
    t_height_next = t_height;
    col_next      = col;
    row_next      = row;
    base_x_next   = base_x;
    base_y_next   = base_y;
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    push_entry    = '0;
    if (active) begin
      push_entry.kind = KIND_PIXEL;
      push_entry.cls  = CLS_LOAD;
      push_entry.x0   = 10'(cur_x);
      push_entry.y0   = 9'(cur_y);
      push_entry.v0   = in_data[15:0];
      if (end0) begin
        active_next = 1'b0;
        col_next    = 16'd0;
        row_next    = row_a;
      end else begin
        push_entry.two = 1'b1;
        push_entry.x1  = 10'(x_a);
        push_entry.y1  = 9'(y_a);
        push_entry.v1  = in_data[31:16];
        col_next       = wrap1 ? 16'd0 : c2[15:0];
        row_next       = wrap1 ? r2[15:0] : row_a;
        cur_x_next     = wrap1 ? base_x : step_x(x_a);
        cur_y_next     = wrap1 ? step_y(y_a) : y_a;
        active_next    = !end1;
      end
    end else if (count_inc < need) begin
      push_entry.kind = KIND_BUFFERED;
      push_entry.cls  = (cls == CLS_UNKNOWN) ? CLS_NOP : cls;
      count_next      = count + CW'(1);
    end else begin
      count_next = '0;
      if (cls == CLS_UNKNOWN) begin
        push_entry.kind = KIND_ERROR;
        push_entry.cls  = CLS_NOP;
      end else begin
        push_entry.kind = KIND_DONE;
        push_entry.cls  = cls;
        if (cls == CLS_LOAD) begin
          t_width_next  = in_data[15:0];
          t_height_next = in_data[31:16];
          col_next      = 16'd0;
          row_next      = 16'd0;
          base_x_next   = start_x_mod;
          base_y_next   = start_y_mod;
          cur_x_next    = start_x_mod;
          cur_y_next    = start_y_mod;
          active_next   = (in_data[15:0] != 16'd0) && (in_data[31:16] != 16'd0);
        end else if (cls == CLS_ATTR) begin
          push_entry.attr_we  = 1'b1;
          push_entry.attr_sel = op[2:0];
          push_entry.attr_val = attr_val;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      active <= 1'b0;
      col    <= 16'd0;
      row    <= 16'd0;
    end else if (push) begin
      count  <= count_next;
      active <= active_next;
      col    <= col_next;
      row    <= row_next;
    end
  end

  // Packet words and transfer geometry.
  always_ff @(posedge clk) begin
    if (push) begin
      t_width  <= t_width_next;
      t_height <= t_height_next;
      base_x   <= base_x_next;
      base_y   <= base_y_next;
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      if (!active && count == '0) begin
        op_byte <= in_data[31:24];
        op_low  <= in_data[21:0];
      end
      if (!active && count == CW'(1)) begin
        w1_x <= in_data[15:0];
        w1_y <= in_data[31:16];
        q_x  <= prod_x[39:24];
        q_y  <= prod_y[39:24];
      end
    end
  end

endmodule

// ===== rtl/gcpd_queue.sv =====
// Short queue of work entries between the front and back ends.
module gcpd_queue import gcpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  gcpd_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output gcpd_entry_t pop_entry,
  output logic        empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  gcpd_entry_t   slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fill;

  assign full      = (fill == (PW + 1)'(QUEUE_DEPTH));
  assign empty     = (fill == '0);
  assign pop_entry = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/gcpd_back.sv =====
// Back end: splits pixel words into beats, applies attributes, holds the result.
module gcpd_back import gcpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  gcpd_entry_t  q_entry,
  output logic         q_pop,
  output logic         res_valid,
  input  logic         res_ready,
  output gcpd_result_t res
);

  logic        half;
  logic        load;
  logic        first_of_two;
  logic [13:0] mode_reg, mode_next;
  logic [19:0] window_reg, window_next;
  logic [19:0] top_left_reg, top_left_next;
  logic [19:0] bottom_right_reg, bottom_right_next;
  logic [21:0] offset_reg, offset_next;
  logic [1:0]  mask_reg, mask_next;
  gcpd_result_t res_next;

  // The output register takes a new beat when empty or being drained.
  assign load         = !q_empty && (!res_valid || res_ready);
  assign first_of_two = q_entry.two && !half;
  assign q_pop        = load && !first_of_two;

  // Attribute registers after this entry.
  always_comb begin
    mode_next         = mode_reg;
    window_next       = window_reg;
    top_left_next     = top_left_reg;
    bottom_right_next = bottom_right_reg;
    offset_next       = offset_reg;
    mask_next         = mask_reg;
    if (q_entry.attr_we) begin
      case (q_entry.attr_sel)
        ATTR_MODE:   mode_next         = q_entry.attr_val[13:0];
        ATTR_WINDOW: window_next       = q_entry.attr_val[19:0];
        ATTR_TL:     top_left_next     = q_entry.attr_val[19:0];
        ATTR_BR:     bottom_right_next = q_entry.attr_val[19:0];
        ATTR_OFFSET: offset_next       = q_entry.attr_val;
        ATTR_MASK:   mask_next         = q_entry.attr_val[1:0];
        default:     mask_next         = mask_reg;
      endcase
    end
  end

  // Result beat built from the head entry.
  always_comb begin
    res_next.result_kind       = q_entry.kind;
    res_next.command_class     = q_entry.cls;
    res_next.pixel_x           = half ? q_entry.x1 : q_entry.x0;
    res_next.pixel_y           = half ? q_entry.y1 : q_entry.y0;
    res_next.pixel_value       = half ? q_entry.v1 : q_entry.v0;
    res_next.last_in_run       = !first_of_two;
    res_next.draw_mode         = mode_next;
    res_next.texture_window    = window_next;
    res_next.area_top_left     = top_left_next;
    res_next.area_bottom_right = bottom_right_next;
    res_next.drawing_offset    = offset_next;
    res_next.mask_setting      = mask_next;
  end

  // Control state and attribute registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid        <= 1'b0;
      half             <= 1'b0;
      mode_reg         <= '0;
      window_reg       <= '0;
      top_left_reg     <= '0;
      bottom_right_reg <= '0;
      offset_reg       <= '0;
      mask_reg         <= '0;
    end else if (load) begin
      res_valid        <= 1'b1;
      half             <= first_of_two;
      mode_reg         <= mode_next;
      window_reg       <= window_next;
      top_left_reg     <= top_left_next;
      bottom_right_reg <= bottom_right_next;
      offset_reg       <= offset_next;
      mask_reg         <= mask_next;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/gpu_command_packet_decoder_core.sv =====
// A word's entry is stored in a queue slot, then its first result beat in the output register.
// Throughput: one command word per cycle while the queue is not full; a pixel word of a load
// gives up to two result beats, which leave one at a time through the single result port of the back end.
// A four-entry queue lets the word and result sides stall independently.
// Reset (synchronous, active high) clears the packet count, the transfer, the
// attribute registers and the queue; no clearing pass is needed.
module gpu_command_packet_decoder_core import gcpd_pkg::*; #(
  parameter int MAX_PACKET_WORDS = MAX_PACKET_WORDS_DEF,
  parameter int FRAME_WIDTH      = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT     = FRAME_HEIGHT_DEF
) (
  input logic          clk,
  input logic          rst,
  gcpd_cmd_if.sink     cmd,
  gcpd_result_if.source result
);

  logic         push, q_full, q_empty, q_pop;
  gcpd_entry_t  push_entry, q_entry;
  gcpd_result_t res;

  // Packet gathering and transfer tracking.
  gcpd_front #(
    .MAX_PACKET_WORDS (MAX_PACKET_WORDS),
    .FRAME_WIDTH      (FRAME_WIDTH),
    .FRAME_HEIGHT     (FRAME_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_data    (cmd.data_word),
    .in_ready   (cmd.ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  gcpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_entry),
    .empty      (q_empty)
  );

  // Result generation.
  gcpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res       (res)
  );

  assign result.result_kind       = res.result_kind;
  assign result.command_class     = res.command_class;
  assign result.pixel_x           = res.pixel_x;
  assign result.pixel_y           = res.pixel_y;
  assign result.pixel_value       = res.pixel_value;
  assign result.last_in_run       = res.last_in_run;
  assign result.draw_mode         = res.draw_mode;
  assign result.texture_window    = res.texture_window;
  assign result.area_top_left     = res.area_top_left;
  assign result.area_bottom_right = res.area_bottom_right;
  assign result.drawing_offset    = res.drawing_offset;
  assign result.mask_setting      = res.mask_setting;

endmodule
